### hw/rtl/lrsr_pkg.sv
// shared types and constants for the shift-reduce parse engine
// no dependencies
package lrsr_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_SYMBOLS = 256;
  localparam int NUM_RULES   = 256;
  localparam int STACK_DEPTH = 256;
  localparam int MAX_RHS     = 16;
  localparam int MAX_RED     = 63;

  localparam int STATE_W  = $clog2(NUM_STATES);
  localparam int SYM_W    = $clog2(NUM_SYMBOLS);
  localparam int ACT_AW   = STATE_W + SYM_W;
  localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int ACT_DW   = 2 + STATE_W;
  localparam int RULE_AW  = $clog2(NUM_RULES);
  localparam int LEN_W    = 5;
  localparam int RULE_DW  = 8 + LEN_W;
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int RED_W    = $clog2(MAX_RED + 1);

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SHIFT  = 2'd1;
  localparam logic [1:0] KIND_REDUCE = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD_ACTION = 2'd0,
    OP_LOAD_RULE   = 2'd1,
    OP_TOKEN       = 2'd2,
    OP_END         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_REDUCE   = 2'd0,
    RES_ERROR    = 2'd1,
    RES_ACCEPT   = 2'd2,
    RES_NO_START = 2'd3
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_ACT,
    ST_RULE,
    ST_GSTK,
    ST_GACT,
    ST_FIN
  } state_t;

endpackage

### hw/rtl/lrsr_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lrsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lr_shift_reduce_parse_engine.sv
// top level of the table-driven shift-reduce parse engine
// depends on lrsr_pkg and lrsr_ram (action table, rule table, state stack)
// loads are taken in idle and end of input passes through fin; a token passes lookup and act for
// a shift, plus rule, gstk, gact, lookup and act per reduction, then fin for the last reduction
// one item in flight at a time; results leave through a single output register
// after reset a clearing pass empties the action table and state stack; no request taken meanwhile
module lr_shift_reduce_parse_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic [7:0]             from_state,
  input  logic [7:0]             symbol_id,
  input  logic [1:0]             action_kind,
  input  logic [7:0]             action_target,
  input  logic [7:0]             rule_index,
  input  logic [7:0]             rule_lhs,
  input  logic [4:0]             rule_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             result_kind,
  output logic [7:0]             rule_number,
  output logic [31:0]            error_position,
  output logic                   last_of_run,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);
  import lrsr_pkg::*;

  state_t state, state_next;
  logic [SP_W-1:0]    sp, sp_next;
  logic [STATE_W-1:0] top, top_next;
  logic [31:0]        tokens_read, tokens_read_next;
  logic               halted, halted_next;
  logic [7:0]         start_rule, start_rule_next;
  logic               start_rule_seen, start_rule_seen_next;
  logic [7:0]         start_symbol;
  logic [SYM_W-1:0]   sym, sym_next;
  logic [7:0]         lhs, lhs_next;
  logic [RED_W-1:0]   red_cnt, red_cnt_next;
  logic               pend, pend_next;
  logic [7:0]         pend_rule, pend_rule_next;
  result_t            fin, fin_next;
  logic [ACT_AW-1:0]  clr_cnt, clr_cnt_next;

  logic               out_load, out_last;
  result_t            out_kind;
  logic [7:0]         out_rule;
  logic [31:0]        out_pos;
  logic               out_free;

  logic               act_we, rule_we, stk_we;
  logic [ACT_AW-1:0]  act_waddr, act_raddr;
  logic [ACT_DW-1:0]  act_wdata, act_rdata;
  logic [RULE_AW-1:0] rule_waddr, rule_raddr;
  logic [RULE_DW-1:0] rule_wdata, rule_rdata;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [STATE_W-1:0] stk_wdata, stk_rdata;

  logic [1:0]         a_kind;
  logic [STATE_W-1:0] a_tgt;
  logic [LEN_W-1:0]   r_len;
  logic [SP_W-1:0]    sp_pop, sp_pop_m1;
  logic [1:0]         ld_kind;
  logic [LEN_W-1:0]   ld_len;

  lrsr_ram #(.WIDTH(ACT_DW), .DEPTH(ACT_DEPTH)) u_act (
    .clk, .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rdata)
  );

  lrsr_ram #(.WIDTH(RULE_DW), .DEPTH(NUM_RULES)) u_rule (
    .clk, .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
    .raddr(rule_raddr), .rdata(rule_rdata)
  );

  lrsr_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign a_kind    = act_rdata[ACT_DW-1 -: 2];
  assign a_tgt     = act_rdata[STATE_W-1:0];
  assign r_len     = rule_rdata[LEN_W-1:0];
  assign sp_pop    = sp - SP_W'(r_len);
  assign sp_pop_m1 = sp_pop - SP_W'(1);
  assign ld_kind   = (action_kind == KIND_BAD) ? KIND_NONE : action_kind;
  assign ld_len    = (rule_length > LEN_W'(MAX_RHS)) ? LEN_W'(MAX_RHS) : rule_length;

  always_comb begin
    state_next           = state;
    sp_next              = sp;
    top_next             = top;
    tokens_read_next     = tokens_read;
    halted_next          = halted;
    start_rule_next      = start_rule;
    start_rule_seen_next = start_rule_seen;
    sym_next             = sym;
    lhs_next             = lhs;
    red_cnt_next         = red_cnt;
    pend_next            = pend;
    pend_rule_next       = pend_rule;
    fin_next             = fin;
    clr_cnt_next         = clr_cnt;
    out_load             = 1'b0;
    out_kind             = RES_REDUCE;
    out_rule             = '0;
    out_pos              = '0;
    out_last             = 1'b0;
    act_we               = 1'b0;
    act_waddr            = {from_state[STATE_W-1:0], symbol_id[SYM_W-1:0]};
    act_wdata            = {ld_kind,
                            (ld_kind == KIND_NONE) ? STATE_W'(0) : action_target[STATE_W-1:0]};
    act_raddr            = {top, sym};
    rule_we              = 1'b0;
    rule_waddr           = rule_index[RULE_AW-1:0];
    rule_wdata           = {rule_lhs, ld_len};
    rule_raddr           = a_tgt[RULE_AW-1:0];
    stk_we               = 1'b0;
    stk_waddr            = sp[STK_AW-1:0];
    stk_wdata            = a_tgt;
    stk_raddr            = sp_pop_m1[STK_AW-1:0];

    unique case (state)
      ST_CLEAR: begin
        act_we       = 1'b1;
        act_waddr    = clr_cnt;
        act_wdata    = '0;
        stk_we       = 1'b1;
        stk_waddr    = clr_cnt[STK_AW-1:0];
        stk_wdata    = '0;
        clr_cnt_next = clr_cnt + ACT_AW'(1);
        if (clr_cnt == ACT_AW'(ACT_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !halted) begin
          unique case (op_t'(operation))
            OP_LOAD_ACTION: begin
              act_we = 1'b1;
            end
            OP_LOAD_RULE: begin
              rule_we = 1'b1;
              if (rule_lhs == start_symbol) begin
                start_rule_next      = rule_index;
                start_rule_seen_next = 1'b1;
              end
            end
            OP_TOKEN: begin
              if (tokens_read != '1) begin
                tokens_read_next = tokens_read + 32'd1;
              end
              sym_next     = symbol_id[SYM_W-1:0];
              red_cnt_next = '0;
              state_next   = ST_LOOKUP;
            end
            OP_END: begin
              fin_next   = start_rule_seen ? RES_ACCEPT : RES_NO_START;
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        state_next = ST_ACT;
      end
      ST_ACT: begin
        priority if (a_kind == KIND_SHIFT) begin
          if (sp >= SP_W'(STACK_DEPTH)) begin
            fin_next   = RES_ERROR;
            state_next = ST_FIN;
          end else begin
            stk_we   = 1'b1;
            top_next = a_tgt;
            sp_next  = sp + SP_W'(1);
            fin_next = RES_REDUCE;
            state_next = pend ? ST_FIN : ST_IDLE;
          end
        end else if (a_kind == KIND_REDUCE) begin
          if (red_cnt >= RED_W'(MAX_RED) ||
              {1'b0, a_tgt} >= (STATE_W+1)'(NUM_RULES)) begin
            fin_next   = RES_ERROR;
            state_next = ST_FIN;
          end else if (!pend || out_free) begin
            if (pend) begin
              out_load = 1'b1;
              out_rule = pend_rule;
            end
            pend_next      = 1'b1;
            pend_rule_next = 8'(a_tgt);
            red_cnt_next   = red_cnt + RED_W'(1);
            state_next     = ST_RULE;
          end
        end else begin
          fin_next   = RES_ERROR;
          state_next = ST_FIN;
        end
      end
      ST_RULE: begin
        if (SP_W'(r_len) >= sp) begin
          fin_next   = RES_ERROR;
          state_next = ST_FIN;
        end else begin
          sp_next    = sp_pop;
          lhs_next   = rule_rdata[RULE_DW-1 -: 8];
          state_next = ST_GSTK;
        end
      end
      ST_GSTK: begin
        act_raddr  = {stk_rdata, lhs[SYM_W-1:0]};
        state_next = ST_GACT;
      end
      ST_GACT: begin
        if ((a_kind != KIND_SHIFT && a_kind != KIND_REDUCE) ||
            sp >= SP_W'(STACK_DEPTH)) begin
          fin_next   = RES_ERROR;
          state_next = ST_FIN;
        end else begin
          stk_we     = 1'b1;
          top_next   = a_tgt;
          sp_next    = sp + SP_W'(1);
          state_next = ST_LOOKUP;
        end
      end
      ST_FIN: begin
        // fin of reduce kind means the held reduction is the final result
        if (out_free) begin
          out_load = 1'b1;
          if (pend) begin
            out_rule  = pend_rule;
            out_last  = (fin == RES_REDUCE);
            pend_next = 1'b0;
            if (fin == RES_REDUCE) begin
              state_next = ST_IDLE;
            end
          end else begin
            out_kind   = fin;
            out_rule   = (fin == RES_ACCEPT) ? start_rule : 8'd0;
            out_pos    = (fin == RES_ERROR) ? tokens_read : 32'd0;
            out_last   = 1'b1;
            state_next = ST_IDLE;
            if (fin == RES_ERROR) begin
              halted_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      sp              <= SP_W'(1);
      top             <= '0;
      tokens_read     <= '0;
      halted          <= 1'b0;
      start_rule      <= '0;
      start_rule_seen <= 1'b0;
      start_symbol    <= '0;
      pend            <= 1'b0;
      clr_cnt         <= '0;
      out_valid       <= 1'b0;
      fin             <= RES_REDUCE;
      red_cnt         <= '0;
    end else begin
      state           <= state_next;
      sp              <= sp_next;
      top             <= top_next;
      tokens_read     <= tokens_read_next;
      halted          <= halted_next;
      start_rule      <= start_rule_next;
      start_rule_seen <= start_rule_seen_next;
      pend            <= pend_next;
      clr_cnt         <= clr_cnt_next;
      fin             <= fin_next;
      red_cnt         <= red_cnt_next;
      if (cfg_valid && cfg_ready) begin
        start_symbol <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym       <= sym_next;
    lhs       <= lhs_next;
    pend_rule <= pend_rule_next;
    if (out_load) begin
      result_kind    <= out_kind;
      rule_number    <= out_rule;
      error_position <= out_pos;
      last_of_run    <= out_last;
    end
  end

endmodule

### hw/rtl/lrsr_checker.sv
// port-level checks for the parse engine, bound to the top level
// depends on lrsr_pkg
module lrsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [7:0]  rule_number,
  input logic [31:0] error_position,
  input logic        last_of_run
);
  import lrsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(rule_number))
    else $error("result changed while stalled");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_ERROR |-> last_of_run && rule_number == 8'd0)
    else $error("error result not final");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != RES_ERROR |-> error_position == 32'd0)
    else $error("position on non-error result");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_ACCEPT || result_kind == RES_NO_START) |-> last_of_run)
    else $error("end of input result not final");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && result_kind == RES_ERROR |=> !out_valid)
    else $error("result after error");

endmodule

bind lr_shift_reduce_parse_engine lrsr_checker u_lrsr_checker (.*);

### tb/tb_lr_shift_reduce_parse_engine.sv
// testbench for lr_shift_reduce_parse_engine: table loads, token parsing, end of input
// checks every result against a built-in parser model; depends on lrsr_pkg and the rtl
`timescale 1ns / 1ps
module tb_lr_shift_reduce_parse_engine;
  import lrsr_pkg::*;

  typedef struct {
    op_t        op;
    bit [7:0]   from_st;
    bit [7:0]   sym;
    bit [1:0]   akind;
    bit [7:0]   target;
    bit [7:0]   ridx;
    bit [7:0]   rlhs;
    bit [4:0]   rlen;
  } req_t;

  typedef struct {
    result_t    kind;
    bit [7:0]   rule;
    bit [31:0]  pos;
    bit         last;
  } res_t;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  operation;
  logic [7:0]  from_state, symbol_id, action_target, rule_index, rule_lhs;
  logic [1:0]  action_kind;
  logic [4:0]  rule_length;
  logic        out_valid, out_ready;
  logic [1:0]  result_kind;
  logic [7:0]  rule_number;
  logic [31:0] error_position;
  logic        last_of_run;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;

  lr_shift_reduce_parse_engine u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .from_state(from_state), .symbol_id(symbol_id),
    .action_kind(action_kind), .action_target(action_target),
    .rule_index(rule_index), .rule_lhs(rule_lhs), .rule_length(rule_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .rule_number(rule_number),
    .error_position(error_position), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // parser model state
  bit [9:0]    act_tbl [0:65535];
  bit [12:0]   rule_tbl [0:255];
  bit          rule_wr [0:255];
  bit [7:0]    stk [0:255];
  int unsigned sp = 1;
  bit [31:0]   tok_cnt;
  bit          halted;
  bit [7:0]    start_rule;
  bit          start_seen;
  bit [7:0]    start_sym;

  res_t        pending_results[$];
  int          err_cnt;
  int          n_items;
  bit          quiet;
  int          stall_left;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // walk one token; commit updates the model, otherwise a dry run that reports trouble
  function automatic bit parse_tok(bit [7:0] sym, bit commit);
    bit [7:0]    s [0:255];
    int unsigned p;
    int          red;
    bit [9:0]    e, g;
    bit [12:0]   rr;
    bit          failed, bad;
    res_t        r;
    res_t        rs[$];
    s = stk;
    p = sp;
    red = 0;
    failed = 0;
    bad = 0;
    while (1) begin
      e = act_tbl[{s[p-1], sym}];
      if (e[9:8] == KIND_SHIFT) begin
        if (p >= STACK_DEPTH) failed = 1;
        else begin
          s[p] = e[7:0];
          p++;
        end
        break;
      end
      if (e[9:8] != KIND_REDUCE || red >= MAX_RED) begin
        failed = 1;
        break;
      end
      if (!rule_wr[e[7:0]]) begin
        bad = 1;
        break;
      end
      r.kind = RES_REDUCE; r.rule = e[7:0]; r.pos = 0; r.last = 0;
      rs.insert(rs.size(), r);
      red++;
      rr = rule_tbl[e[7:0]];
      if (rr[4:0] >= p) begin
        failed = 1;
        break;
      end
      p -= rr[4:0];
      g = act_tbl[{s[p-1], rr[12:5]}];
      if ((g[9:8] != KIND_SHIFT && g[9:8] != KIND_REDUCE) || p >= STACK_DEPTH) begin
        failed = 1;
        break;
      end
      s[p] = g[7:0];
      p++;
    end
    if (commit) begin
      if (tok_cnt != 32'hFFFF_FFFF) tok_cnt++;
      if (failed) begin
        r.kind = RES_ERROR; r.rule = 0; r.pos = tok_cnt; r.last = 0;
        rs.insert(rs.size(), r);
        halted = 1;
      end
      if (rs.size() > 0) rs[rs.size()-1].last = 1;
      foreach (rs[i]) pending_results.insert(pending_results.size(), rs[i]);
      stk = s;
      sp = p;
    end
    return failed || bad;
  endfunction

  function automatic void model_step(req_t q);
    bit [1:0] k;
    res_t     r;
    if (halted) return;
    case (q.op)
      OP_LOAD_ACTION: begin
        k = (q.akind == KIND_BAD) ? KIND_NONE : q.akind;
        act_tbl[{q.from_st, q.sym}] = {k, (k == KIND_NONE) ? 8'd0 : q.target};
      end
      OP_LOAD_RULE: begin
        rule_tbl[q.ridx] = {q.rlhs, (q.rlen > MAX_RHS) ? 5'(MAX_RHS) : q.rlen};
        rule_wr[q.ridx] = 1;
        if (q.rlhs == start_sym) begin
          start_rule = q.ridx;
          start_seen = 1;
        end
      end
      OP_TOKEN: void'(parse_tok(q.sym, 1));
      default: begin
        r.kind = start_seen ? RES_ACCEPT : RES_NO_START;
        r.rule = start_seen ? start_rule : 8'd0;
        r.pos = 0;
        r.last = 1;
        pending_results.insert(pending_results.size(), r);
      end
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.op = op_t'($urandom_range(0, 3));
    q.from_st = 8'($urandom); q.sym = 8'($urandom); q.akind = 2'($urandom);
    q.target = 8'($urandom); q.ridx = 8'($urandom); q.rlhs = 8'($urandom);
    q.rlen = 5'($urandom);
    return q;
  endfunction

  function automatic req_t mk_action(bit [7:0] st, bit [7:0] sym, bit [1:0] k, bit [7:0] t);
    req_t q;
    q = rand_req();
    q.op = OP_LOAD_ACTION; q.from_st = st; q.sym = sym; q.akind = k; q.target = t;
    return q;
  endfunction

  function automatic req_t mk_rule(bit [7:0] idx, bit [7:0] lhs, bit [4:0] len);
    req_t q;
    q = rand_req();
    q.op = OP_LOAD_RULE; q.ridx = idx; q.rlhs = lhs; q.rlen = len;
    return q;
  endfunction

  function automatic req_t mk_token(bit [7:0] sym);
    req_t q;
    q = rand_req();
    q.op = OP_TOKEN; q.sym = sym;
    return q;
  endfunction

  function automatic req_t mk_end();
    req_t q;
    q = rand_req();
    q.op = OP_END;
    return q;
  endfunction

  task automatic send_req(req_t q);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    operation = q.op; from_state = q.from_st; symbol_id = q.sym;
    action_kind = q.akind; action_target = q.target; rule_index = q.ridx;
    rule_lhs = q.rlhs; rule_length = q.rlen;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    model_step(q);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(bit [7:0] v);
    drain();
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    start_sym = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 9) < 3) stall_left = gap_len();
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    res_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) report("unexpected result kind", result_kind, 0);
      else begin
        x = pending_results.pop_front();
        if (result_kind !== x.kind) report("result_kind", result_kind, x.kind);
        if (rule_number !== x.rule) report("rule_number", rule_number, x.rule);
        if (error_position !== x.pos) report("error_position", error_position, x.pos);
        if (last_of_run !== x.last) report("last_of_run", last_of_run, x.last);
      end
    end
  end

  task automatic test_directed();
    write_cfg(8'd5);
    send_req(mk_end());
    send_req(mk_rule(8'd0, 8'd5, 5'd1));
    send_req(mk_end());
    send_req(mk_rule(8'd255, 8'd255, 5'd31));
    send_req(mk_rule(8'd1, 8'd6, 5'd0));
    send_req(mk_rule(8'd2, 8'd7, 5'd2));
    send_req(mk_action(8'd255, 8'd255, KIND_SHIFT, 8'd255));
    send_req(mk_action(8'd255, 8'd255, KIND_BAD, 8'd255));
    send_req(mk_action(8'd0, 8'd1, KIND_SHIFT, 8'd1));
    send_req(mk_action(8'd1, 8'd2, KIND_SHIFT, 8'd2));
    send_req(mk_action(8'd2, 8'd3, KIND_REDUCE, 8'd2));
    send_req(mk_action(8'd0, 8'd7, KIND_SHIFT, 8'd3));
    send_req(mk_action(8'd3, 8'd3, KIND_REDUCE, 8'd1));
    send_req(mk_action(8'd3, 8'd6, KIND_REDUCE, 8'd4));
    send_req(mk_action(8'd4, 8'd3, KIND_SHIFT, 8'd5));
    send_req(mk_token(8'd1));
    send_req(mk_token(8'd2));
    send_req(mk_token(8'd3));
    send_req(mk_end());
    write_cfg(8'd255);
    send_req(mk_rule(8'd255, 8'd255, 5'd16));
    send_req(mk_end());
  endtask

  task automatic test_random_parse();
    req_t q;
    int   r, tries;
    bit   found;
    write_cfg(8'($urandom_range(0, 7)));
    for (int i = 0; i < 8; i++)
      send_req(mk_rule(8'(i), 8'($urandom_range(0, 7)), 5'($urandom_range(0, 3))));
    for (int i = 0; i < 40; i++)
      send_req(mk_action(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                         2'($urandom_range(1, 2)), 8'($urandom_range(0, 7))));
    while (n_items < 460) begin
      if (n_items == 200) begin
        drain();
        write_cfg(8'd0);
        quiet = 1;
      end
      if (n_items == 260) quiet = 0;
      if (n_items == 330) write_cfg(8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 70) begin
        found = 0;
        for (tries = 0; tries < 10 && !found; tries++) begin
          q = mk_token((tries == 9) ? 8'($urandom) : 8'($urandom_range(0, 7)));
          found = !parse_tok(q.sym, 0);
        end
        if (!found) q = mk_action(stk[sp-1], 8'($urandom_range(0, 7)), KIND_SHIFT,
                                  8'($urandom_range(0, 7)));
      end else if (r < 80) begin
        q = mk_end();
      end else if (r < 90) begin
        q = mk_rule(8'($urandom), 8'($urandom), 5'($urandom));
      end else begin
        q = mk_action(8'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
        if (q.akind == KIND_REDUCE && !rule_wr[q.target])
          q.target = 8'($urandom_range(0, 7));
      end
      send_req(q);
    end
  endtask

  task automatic test_error_halt();
    bit [7:0] top;
    int       pick;
    top = stk[sp-1];
    pick = $urandom_range(0, 4);
    if (pick == 2 && sp > MAX_RHS) pick = 0;
    if (pick == 3 && sp < STACK_DEPTH - 24) pick = 0;
    case (pick)
      0: begin
        send_req(mk_action(top, 8'd251, KIND_NONE, 8'($urandom)));
        send_req(mk_token(8'd251));
      end
      1: begin
        send_req(mk_rule(8'd251, 8'd254, 5'd0));
        send_req(mk_action(top, 8'd250, KIND_REDUCE, 8'd251));
        send_req(mk_action(top, 8'd254, KIND_NONE, 8'd0));
        send_req(mk_token(8'd250));
      end
      2: begin
        send_req(mk_rule(8'd250, 8'd0, 5'(sp)));
        send_req(mk_action(top, 8'd252, KIND_REDUCE, 8'd250));
        send_req(mk_token(8'd252));
      end
      3: begin
        send_req(mk_action(top, 8'd253, KIND_SHIFT, top));
        while (!halted) send_req(mk_token(8'd253));
      end
      default: begin
        send_req(mk_rule(8'd252, 8'd252, 5'd0));
        send_req(mk_action(top, 8'd253, KIND_REDUCE, 8'd252));
        send_req(mk_action(top, 8'd252, KIND_SHIFT, top));
        send_req(mk_token(8'd253));
      end
    endcase
    // halted: everything below is ignored
    send_req(mk_token(8'($urandom)));
    send_req(mk_end());
    send_req(mk_rule(8'($urandom), 8'($urandom), 5'($urandom)));
    send_req(mk_action(8'($urandom), 8'($urandom), 2'($urandom), 8'($urandom)));
    send_req(mk_end());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0; from_state = '0; symbol_id = '0; action_kind = '0;
    action_target = '0; rule_index = '0; rule_lhs = '0; rule_length = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_parse();
    test_error_halt();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
